FILE: rtl/trapezoidal_axis_motion_sequencer_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the trapezoidal axis motion sequencer
// Concurrent checks, compiled away in synthesis.
// ----------------------------------------------------------------------------
`ifndef TRAPEZOIDAL_AXIS_MOTION_SEQUENCER_MACROS_SVH
`define TRAPEZOIDAL_AXIS_MOTION_SEQUENCER_MACROS_SVH

`ifndef SYNTHESIS
// explicit clock and reset
`define TAMS_ASSERT_CLK(lbl, ck, rn, prop, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) prop) else $error(msg);
// default clock clk, reset rst_n
`define TAMS_ASSERT(lbl, prop, msg) \
  `TAMS_ASSERT_CLK(lbl, clk, rst_n, prop, msg)
`else
`define TAMS_ASSERT_CLK(lbl, ck, rn, prop, msg)
`define TAMS_ASSERT(lbl, prop, msg)
`endif

`endif

FILE: rtl/tams_pkg.sv
// ----------------------------------------------------------------------------
// tams_pkg
// Types and codes shared by the motion sequencer modules.
// ----------------------------------------------------------------------------
`default_nettype none

package tams_pkg;

  localparam int SPEED_W = 15;

  typedef enum logic [2:0] {
    OP_START      = 3'd0,
    OP_STOP       = 3'd1,
    OP_RESET      = 3'd2,
    OP_ENC_EDGE   = 3'd3,
    OP_HOME_SW    = 3'd4,
    OP_FAR_SW     = 3'd5,
    OP_ACCEL_TICK = 3'd6,
    OP_STEP_TICK  = 3'd7
  } opcode_t;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_MOVING     = 3'd1,
    ST_FAR_LIMIT  = 3'd2,
    ST_HOME_LIMIT = 3'd3,
    ST_BAD_PROF   = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    SEG_ACCEL = 2'd0,
    SEG_HOLD  = 2'd1,
    SEG_DECEL = 2'd2
  } segment_t;

  // input item payload, last field in the lowest bits
  typedef struct packed {
    logic [6:0]          fill;
    logic                switch_level;
    logic                profile_ok;
    logic signed [31:0]  decel_distance;
    logic signed [31:0]  hold_distance;
    logic signed [31:0]  accel_distance;
    logic [SPEED_W-1:0]  hold_speed;
    logic [SPEED_W-1:0]  start_speed;
    logic                move_negative;
  } in_data_t;

  // result item payload, last field in the lowest bits
  typedef struct packed {
    logic                far_hit;
    logic                home_hit;
    logic                dir_pin;
    logic signed [31:0]  position;
    segment_t            segment;
    logic                speed_reload;
    logic [SPEED_W-1:0]  pending_speed;
    logic [SPEED_W-1:0]  applied_speed;
    logic                is_moving;
    status_t             status;
  } out_data_t;

endpackage

`default_nettype wire

FILE: rtl/trapezoidal_axis_motion_sequencer.sv
// An accepted item passes the input register, then the result register, to out_tvalid.
// Throughput: one item per cycle while the result is not stalled; the axis state updates once per item,
// so back-to-back events each see the state left by the one before.
// in_tready drops only while the input register is full and the result is stalled.
// Reset: synchronous, active low; clears the axis state, the limit flags, both
// registers' valid flags and the switch level register.
// ----------------------------------------------------------------------------
// trapezoidal_axis_motion_sequencer
// Event-driven single-axis trapezoidal motion sequencer with stream ports.
// ----------------------------------------------------------------------------
`default_nettype none

`include "trapezoidal_axis_motion_sequencer_macros.svh"

module trapezoidal_axis_motion_sequencer #(
  parameter int POSITION_WIDTH = 32,
  parameter int MAX_SPEED      = 25000
) (
  input  wire          clk,
  input  wire          rst_n,
  input  wire          cfg_wr_en,
  input  wire          cfg_wr_data,    // switch_pressed_level
  input  wire          in_tvalid,
  output logic         in_tready,
  // move_negative, start_speed, hold_speed, accel_distance, hold_distance,
  // decel_distance, profile_ok, switch_level, zero fill
  input  wire  [135:0] in_tdata,
  input  wire  [2:0]   in_tuser,       // opcode
  output logic         out_tvalid,
  input  wire          out_tready,
  // status, is_moving, applied_speed, pending_speed, speed_reload, segment,
  // position, dir_pin, home_hit, far_hit
  output logic [71:0]  out_tdata
);

  logic                 pressed_level_r;
  logic                 in_valid_r, in_valid_nxt;
  tams_pkg::opcode_t    in_op_r;
  tams_pkg::in_data_t   in_data_r;
  logic                 out_valid_r, out_valid_nxt;
  tams_pkg::out_data_t  out_data_r;
  tams_pkg::out_data_t  result;
  logic                 in_take;
  logic                 advance;

  assign advance   = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || advance;
  assign in_take   = in_tvalid && in_tready;

  always_comb begin
    in_valid_nxt = in_valid_r;
    if (in_take) begin
      in_valid_nxt = 1'b1;
    end else if (advance) begin
      in_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (advance) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pressed_level_r <= 1'b0;
      in_valid_r      <= 1'b0;
      out_valid_r     <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        pressed_level_r <= cfg_wr_data;
      end
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    if (in_take) begin
      in_op_r   <= tams_pkg::opcode_t'(in_tuser);
      in_data_r <= tams_pkg::in_data_t'(in_tdata);
    end
    if (advance) begin
      out_data_r <= result;
    end
  end

  tams_axis_core #(
    .POSITION_WIDTH (POSITION_WIDTH),
    .MAX_SPEED      (MAX_SPEED)
  ) u_core (
    .clk           (clk),
    .rst_n         (rst_n),
    .step_en       (advance),
    .opcode        (in_op_r),
    .item          (in_data_r),
    .pressed_level (pressed_level_r),
    .result        (result)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  `TAMS_ASSERT(a_stall_blocks_input,
               (in_valid_r && out_valid_r && !out_tready) |-> !in_tready,
               "input taken while result register is stalled")
  `TAMS_ASSERT(a_advance_fills_output,
               advance |=> out_valid_r,
               "processed item did not reach the result register")
  `TAMS_ASSERT(a_speed_limit,
               out_valid_r |-> ({1'b0, out_data_r.pending_speed} <= 16'(MAX_SPEED) &&
                                {1'b0, out_data_r.applied_speed} <= 16'(MAX_SPEED)),
               "speed above the configured maximum")
  `TAMS_ASSERT(a_reject_no_reload,
               (out_valid_r && out_data_r.status != tams_pkg::ST_OK) |->
                 !out_data_r.speed_reload,
               "reload flagged on a rejected start")

endmodule

`default_nettype wire

FILE: rtl/tams_axis_core.sv
// ----------------------------------------------------------------------------
// tams_axis_core
// Axis state registers and the combinational event update that forms a result.
// ----------------------------------------------------------------------------
`default_nettype none

module tams_axis_core #(
  parameter int POSITION_WIDTH = 32,
  parameter int MAX_SPEED      = 25000
) (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   step_en,
  input  tams_pkg::opcode_t     opcode,
  input  tams_pkg::in_data_t    item,
  input  wire                   pressed_level,
  output tams_pkg::out_data_t   result
);

  typedef logic signed [POSITION_WIDTH-1:0] pos_t;
  typedef logic [tams_pkg::SPEED_W-1:0]     spd_t;

  localparam logic [15:0] MAX_SPD = 16'(MAX_SPEED);

  function automatic spd_t sat_speed(input spd_t v);
    if ({1'b0, v} > MAX_SPD) begin
      return spd_t'(MAX_SPD);
    end
    return v;
  endfunction

  logic                 moving_r, moving_nxt;
  spd_t                 cur_spd_r, cur_spd_nxt;
  spd_t                 next_spd_r, next_spd_nxt;
  tams_pkg::segment_t   seg_r, seg_nxt;
  pos_t                 enc_r, enc_nxt;
  pos_t                 target_r, target_nxt;
  logic                 dir_neg_r, dir_neg_nxt;
  spd_t                 mv_start_r, mv_start_nxt;
  spd_t                 mv_hold_r, mv_hold_nxt;
  logic signed [31:0]   mv_hold_dist_r, mv_hold_dist_nxt;
  logic signed [31:0]   mv_decel_dist_r, mv_decel_dist_nxt;
  logic                 home_r, home_nxt;
  logic                 far_r, far_nxt;

  tams_pkg::status_t    status;
  logic                 reload;
  logic                 reached;
  logic                 sw_pressed;

  // signed compare at the position width, sense follows the direction
  assign reached    = dir_neg_r ? (enc_r <= target_r) : (enc_r >= target_r);
  assign sw_pressed = (item.switch_level == pressed_level);

  always_comb begin
    moving_nxt        = moving_r;
    cur_spd_nxt       = cur_spd_r;
    next_spd_nxt      = next_spd_r;
    seg_nxt           = seg_r;
    enc_nxt           = enc_r;
    target_nxt        = target_r;
    dir_neg_nxt       = dir_neg_r;
    mv_start_nxt      = mv_start_r;
    mv_hold_nxt       = mv_hold_r;
    mv_hold_dist_nxt  = mv_hold_dist_r;
    mv_decel_dist_nxt = mv_decel_dist_r;
    home_nxt          = home_r;
    far_nxt           = far_r;
    status            = tams_pkg::ST_OK;
    reload            = 1'b0;

    case (opcode)
      tams_pkg::OP_START: begin
        if (moving_r) begin
          status = tams_pkg::ST_MOVING;
        end else if (!item.move_negative && far_r) begin
          status = tams_pkg::ST_FAR_LIMIT;
        end else if (item.move_negative && home_r) begin
          status = tams_pkg::ST_HOME_LIMIT;
        end else if (!item.profile_ok) begin
          status = tams_pkg::ST_BAD_PROF;
        end else begin
          mv_start_nxt      = sat_speed(item.start_speed);
          mv_hold_nxt       = sat_speed(item.hold_speed);
          mv_hold_dist_nxt  = item.hold_distance;
          mv_decel_dist_nxt = item.decel_distance;
          moving_nxt        = 1'b1;
          cur_spd_nxt       = sat_speed(item.start_speed);
          next_spd_nxt      = sat_speed(item.start_speed);
          seg_nxt           = tams_pkg::SEG_ACCEL;
          target_nxt        = enc_r + pos_t'(item.accel_distance);
          dir_neg_nxt       = item.move_negative;
          reload            = 1'b1;
        end
      end
      tams_pkg::OP_STOP: begin
        moving_nxt   = 1'b0;
        cur_spd_nxt  = '0;
        next_spd_nxt = '0;
      end
      tams_pkg::OP_RESET: begin
        moving_nxt   = 1'b0;
        cur_spd_nxt  = '0;
        next_spd_nxt = '0;
        enc_nxt      = '0;
        target_nxt   = '0;
        dir_neg_nxt  = 1'b0;
      end
      tams_pkg::OP_ENC_EDGE: begin
        enc_nxt = dir_neg_r ? enc_r - pos_t'(1) : enc_r + pos_t'(1);
      end
      tams_pkg::OP_HOME_SW: begin
        moving_nxt   = 1'b0;
        cur_spd_nxt  = '0;
        next_spd_nxt = '0;
        home_nxt     = sw_pressed;
      end
      tams_pkg::OP_FAR_SW: begin
        moving_nxt   = 1'b0;
        cur_spd_nxt  = '0;
        next_spd_nxt = '0;
        far_nxt      = sw_pressed;
      end
      tams_pkg::OP_ACCEL_TICK: begin
        if (moving_r) begin
          case (seg_r)
            tams_pkg::SEG_ACCEL: begin
              if (next_spd_r < mv_hold_r) begin
                next_spd_nxt = next_spd_r + spd_t'(1);
              end else begin
                seg_nxt    = tams_pkg::SEG_HOLD;
                target_nxt = target_r + pos_t'(mv_hold_dist_r);
              end
            end
            tams_pkg::SEG_HOLD: begin
              if (reached) begin
                seg_nxt    = tams_pkg::SEG_DECEL;
                target_nxt = target_r + pos_t'(mv_decel_dist_r);
              end
            end
            tams_pkg::SEG_DECEL: begin
              if (!reached) begin
                if (next_spd_r > mv_start_r) begin
                  next_spd_nxt = next_spd_r - spd_t'(1);
                end
              end else begin
                moving_nxt   = 1'b0;
                cur_spd_nxt  = '0;
                next_spd_nxt = '0;
              end
            end
            default: begin
            end
          endcase
        end
      end
      tams_pkg::OP_STEP_TICK: begin
        if (next_spd_r != cur_spd_r) begin
          cur_spd_nxt = next_spd_r;
          reload      = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      moving_r        <= 1'b0;
      cur_spd_r       <= '0;
      next_spd_r      <= '0;
      seg_r           <= tams_pkg::SEG_ACCEL;
      enc_r           <= '0;
      target_r        <= '0;
      dir_neg_r       <= 1'b0;
      mv_start_r      <= '0;
      mv_hold_r       <= '0;
      mv_hold_dist_r  <= '0;
      mv_decel_dist_r <= '0;
      home_r          <= 1'b0;
      far_r           <= 1'b0;
    end else if (step_en) begin
      moving_r        <= moving_nxt;
      cur_spd_r       <= cur_spd_nxt;
      next_spd_r      <= next_spd_nxt;
      seg_r           <= seg_nxt;
      enc_r           <= enc_nxt;
      target_r        <= target_nxt;
      dir_neg_r       <= dir_neg_nxt;
      mv_start_r      <= mv_start_nxt;
      mv_hold_r       <= mv_hold_nxt;
      mv_hold_dist_r  <= mv_hold_dist_nxt;
      mv_decel_dist_r <= mv_decel_dist_nxt;
      home_r          <= home_nxt;
      far_r           <= far_nxt;
    end
  end

  // result shows the state after the event
  always_comb begin
    result.status        = status;
    result.is_moving     = moving_nxt;
    result.applied_speed = cur_spd_nxt;
    result.pending_speed = next_spd_nxt;
    result.speed_reload  = reload;
    result.segment       = seg_nxt;
    result.position      = 32'(enc_nxt);
    result.dir_pin       = dir_neg_nxt;
    result.home_hit      = home_nxt;
    result.far_hit       = far_nxt;
  end

endmodule

`default_nettype wire

FILE: sim/trapezoidal_axis_motion_sequencer_test.sv
// ----------------------------------------------------------------------------
// trapezoidal_axis_motion_sequencer_test
// Drives event items into the motion sequencer and checks every result item
// against a cycle-free model of the axis state, kept in a scoreboard. Covers
// start checks, limit switches, resets, full trapezoid moves and back-pressure.
// ----------------------------------------------------------------------------
`default_nettype none

module trapezoidal_axis_motion_sequencer_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SPEED_CAP    = 25000;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = 6;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         cfg_wr_en = 1'b0;
  logic         cfg_wr_data = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [135:0] in_tdata = '0;   // move_negative, start_speed, hold_speed, accel_distance,
                                 // hold_distance, decel_distance, profile_ok, switch_level
  logic [2:0]   in_tuser = '0;   // opcode
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [71:0]  out_tdata;       // status, is_moving, applied_speed, pending_speed,
                                 // speed_reload, segment, position, dir_pin, home_hit, far_hit

  class motion_scoreboard;
    bit                            pressed_level;
    bit                            moving;
    bit                            neg;
    bit                            home_on;
    bit                            far_on;
    logic [tams_pkg::SPEED_W-1:0]  applied;
    logic [tams_pkg::SPEED_W-1:0]  pending;
    logic [tams_pkg::SPEED_W-1:0]  base_spd;
    logic [tams_pkg::SPEED_W-1:0]  cruise_spd;
    tams_pkg::segment_t            seg;
    logic signed [31:0]            count;
    logic signed [31:0]            target;
    logic signed [31:0]            hold_dist;
    logic signed [31:0]            decel_dist;
    tams_pkg::out_data_t           due_q[$];
    int                            failures;

    function new();
      pressed_level = 1'b0;
      moving = 1'b0;
      neg = 1'b0;
      home_on = 1'b0;
      far_on = 1'b0;
      applied = '0;
      pending = '0;
      base_spd = '0;
      cruise_spd = '0;
      seg = tams_pkg::SEG_ACCEL;
      count = '0;
      target = '0;
      hold_dist = '0;
      decel_dist = '0;
      failures = 0;
    endfunction

    function logic [tams_pkg::SPEED_W-1:0] cap_speed(logic [tams_pkg::SPEED_W-1:0] v);
      return (v > SPEED_CAP) ? tams_pkg::SPEED_W'(SPEED_CAP) : v;
    endfunction

    function void halt();
      moving = 1'b0;
      applied = '0;
      pending = '0;
    endfunction

    // signed compare, direction decides which side counts as reached
    function bit at_target();
      return neg ? (count <= target) : (count >= target);
    endfunction

    function void note_event(tams_pkg::opcode_t op, tams_pkg::in_data_t d);
      tams_pkg::out_data_t e;
      tams_pkg::status_t   st;
      bit                  reload;
      st = tams_pkg::ST_OK;
      reload = 1'b0;
      case (op)
        tams_pkg::OP_START: begin
          if (moving) st = tams_pkg::ST_MOVING;
          else if (!d.move_negative && far_on) st = tams_pkg::ST_FAR_LIMIT;
          else if (d.move_negative && home_on) st = tams_pkg::ST_HOME_LIMIT;
          else if (!d.profile_ok) st = tams_pkg::ST_BAD_PROF;
          else begin
            base_spd = cap_speed(d.start_speed);
            cruise_spd = cap_speed(d.hold_speed);
            hold_dist = d.hold_distance;
            decel_dist = d.decel_distance;
            moving = 1'b1;
            applied = base_spd;
            pending = base_spd;
            seg = tams_pkg::SEG_ACCEL;
            target = count + d.accel_distance;
            neg = d.move_negative;
            reload = 1'b1;
          end
        end
        tams_pkg::OP_STOP: halt();
        tams_pkg::OP_RESET: begin
          halt();
          count = '0;
          target = '0;
          neg = 1'b0;
        end
        tams_pkg::OP_ENC_EDGE: count = neg ? count - 1 : count + 1;
        tams_pkg::OP_HOME_SW: begin
          halt();
          home_on = (d.switch_level == pressed_level);
        end
        tams_pkg::OP_FAR_SW: begin
          halt();
          far_on = (d.switch_level == pressed_level);
        end
        tams_pkg::OP_ACCEL_TICK: begin
          if (moving) begin
            case (seg)
              tams_pkg::SEG_ACCEL: begin
                if (pending < cruise_spd) pending = pending + 1'b1;
                else begin
                  seg = tams_pkg::SEG_HOLD;
                  target = target + hold_dist;
                end
              end
              tams_pkg::SEG_HOLD: begin
                if (at_target()) begin
                  seg = tams_pkg::SEG_DECEL;
                  target = target + decel_dist;
                end
              end
              tams_pkg::SEG_DECEL: begin
                if (!at_target()) begin
                  if (pending > base_spd) pending = pending - 1'b1;
                end else begin
                  halt();
                end
              end
              default: ;
            endcase
          end
        end
        tams_pkg::OP_STEP_TICK: begin
          if (pending != applied) begin
            applied = pending;
            reload = 1'b1;
          end
        end
        default: ;
      endcase
      e.status = st;
      e.is_moving = moving;
      e.applied_speed = applied;
      e.pending_speed = pending;
      e.speed_reload = reload;
      e.segment = seg;
      e.position = count;
      e.dir_pin = neg;
      e.home_hit = home_on;
      e.far_hit = far_on;
      due_q.push_back(e);
    endfunction

    function void compare_field(string field, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        $error("%s: expected 0x%0h, actual 0x%0h", field, want, got);
        failures++;
      end
    endfunction

    function void check_result(tams_pkg::out_data_t r);
      tams_pkg::out_data_t e;
      if (due_q.size() == 0) begin
        $error("result item with nothing pending: 0x%0h", r);
        failures++;
        return;
      end
      e = due_q.pop_front();
      compare_field("status", 32'(e.status), 32'(r.status));
      compare_field("is_moving", 32'(e.is_moving), 32'(r.is_moving));
      compare_field("applied_speed", 32'(e.applied_speed), 32'(r.applied_speed));
      compare_field("pending_speed", 32'(e.pending_speed), 32'(r.pending_speed));
      compare_field("speed_reload", 32'(e.speed_reload), 32'(r.speed_reload));
      compare_field("segment", 32'(e.segment), 32'(r.segment));
      compare_field("position", e.position, r.position);
      compare_field("dir_pin", 32'(e.dir_pin), 32'(r.dir_pin));
      compare_field("home_hit", 32'(e.home_hit), 32'(r.home_hit));
      compare_field("far_hit", 32'(e.far_hit), 32'(r.far_hit));
    endfunction
  endclass

  motion_scoreboard sb;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_cycles = 0;
  bit hold_request = 1'b0;
  int items_sent = 0;
  int cycle_count = 0;

  trapezoidal_axis_motion_sequencer DUT (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // receiver: random stalls, plus one long hold-off on request
  always @(posedge clk) begin
    if (hold_request) begin
      hold_request = 1'b0;
      hold_cycles = 80;
    end
    if (hold_cycles > 0) begin
      hold_cycles = hold_cycles - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(tams_pkg::out_data_t'(out_tdata));
  end

  function automatic tams_pkg::in_data_t rand_payload();
    tams_pkg::in_data_t d;
    d.fill = '0;
    d.switch_level = 1'($urandom_range(1));
    d.profile_ok = 1'($urandom_range(1));
    d.decel_distance = $urandom;
    d.hold_distance = $urandom;
    d.accel_distance = $urandom;
    d.hold_speed = 15'($urandom_range(32767));
    d.start_speed = 15'($urandom_range(32767));
    d.move_negative = 1'($urandom_range(1));
    return d;
  endfunction

  // short distance, mostly in the direction of travel
  function automatic logic signed [31:0] short_dist(bit negative);
    int mag;
    mag = $urandom_range(12);
    if ($urandom_range(9) == 0) negative = ~negative;
    return negative ? -mag : mag;
  endfunction

  task automatic send_item(tams_pkg::opcode_t op, tams_pkg::in_data_t d);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= d;
    in_tuser <= op;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_event(op, d);
    items_sent++;
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (sb.due_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_level(bit v);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    sb.pressed_level = v;
  endtask

  // one start followed by ticks and edges until the move ends, with some noise
  task automatic run_move();
    tams_pkg::in_data_t d;
    bit                 dir;
    int                 steps;
    int                 pick;
    dir = 1'($urandom_range(1));
    // release the switch that blocks this direction, most of the time
    if ((dir ? sb.home_on : sb.far_on) && $urandom_range(3) != 0) begin
      d = rand_payload();
      d.switch_level = ~sb.pressed_level;
      send_item(dir ? tams_pkg::OP_HOME_SW : tams_pkg::OP_FAR_SW, d);
    end
    d = rand_payload();
    d.move_negative = dir;
    d.profile_ok = ($urandom_range(9) != 0);
    if ($urandom_range(7) == 0) begin
      d.start_speed = 15'($urandom_range(24990, 32767));
      d.hold_speed = 15'($urandom_range(24990, 32767));
    end else begin
      d.start_speed = 15'($urandom_range(30));
      d.hold_speed = d.start_speed + 15'($urandom_range(12));
    end
    d.accel_distance = short_dist(dir);
    d.hold_distance = short_dist(dir);
    d.decel_distance = short_dist(dir);
    send_item(tams_pkg::OP_START, d);
    steps = 0;
    while (sb.moving && steps < 200) begin
      pick = $urandom_range(99);
      if (pick < 40) send_item(tams_pkg::OP_ACCEL_TICK, rand_payload());
      else if (pick < 75) send_item(tams_pkg::OP_ENC_EDGE, rand_payload());
      else if (pick < 95) send_item(tams_pkg::OP_STEP_TICK, rand_payload());
      else send_item(tams_pkg::opcode_t'($urandom_range(7)), rand_payload());
      steps++;
    end
    repeat ($urandom_range(2)) send_item(tams_pkg::OP_STEP_TICK, rand_payload());
  endtask

  initial begin
    tams_pkg::in_data_t d;
    sb = new();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    write_level(1'b1);

    // idle events, limit switch rejections, bad profile
    send_item(tams_pkg::OP_ENC_EDGE, rand_payload());
    send_item(tams_pkg::OP_ACCEL_TICK, rand_payload());
    send_item(tams_pkg::OP_STEP_TICK, rand_payload());
    d = rand_payload();
    d.switch_level = 1'b1;
    send_item(tams_pkg::OP_FAR_SW, d);
    d.move_negative = 1'b0;
    d.profile_ok = 1'b1;
    send_item(tams_pkg::OP_START, d);
    d.move_negative = 1'b1;
    d.profile_ok = 1'b0;
    send_item(tams_pkg::OP_START, d);
    send_item(tams_pkg::OP_HOME_SW, d);
    d.profile_ok = 1'b1;
    send_item(tams_pkg::OP_START, d);
    d.switch_level = 1'b0;
    send_item(tams_pkg::OP_HOME_SW, d);
    send_item(tams_pkg::OP_FAR_SW, d);

    // saturated speeds and extreme distances, target wraps
    d.start_speed = '1;
    d.hold_speed = '1;
    d.accel_distance = 32'sh8000_0000;
    d.hold_distance = 32'sh7fff_ffff;
    d.decel_distance = '0;
    send_item(tams_pkg::OP_START, d);
    send_item(tams_pkg::OP_START, d);
    send_item(tams_pkg::OP_STEP_TICK, d);
    send_item(tams_pkg::OP_ACCEL_TICK, d);
    send_item(tams_pkg::OP_ENC_EDGE, d);
    send_item(tams_pkg::OP_ACCEL_TICK, d);
    send_item(tams_pkg::OP_STOP, d);
    send_item(tams_pkg::OP_ENC_EDGE, d);
    send_item(tams_pkg::OP_RESET, d);

    // small complete trapezoid
    d.move_negative = 1'b0;
    d.start_speed = '0;
    d.hold_speed = 15'd2;
    d.accel_distance = 32'sd1;
    d.hold_distance = 32'sd2;
    d.decel_distance = 32'sd1;
    send_item(tams_pkg::OP_START, d);
    repeat (2) begin
      send_item(tams_pkg::OP_ACCEL_TICK, d);
      send_item(tams_pkg::OP_STEP_TICK, d);
    end
    send_item(tams_pkg::OP_ACCEL_TICK, d);
    repeat (2) send_item(tams_pkg::OP_ENC_EDGE, d);
    repeat (2) send_item(tams_pkg::OP_ACCEL_TICK, d);
    drain();

    send_idle_pct = 17;
    recv_idle_pct = 49;
    write_level(1'b0);
    while (items_sent < 460) run_move();
    drain();

    send_idle_pct = 49;
    recv_idle_pct = 17;
    write_level(1'b1);
    while (items_sent < 890) run_move();
    drain();

    // no idling; hold off the receiver once so the input backs up
    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_level(1'b0);
    hold_request = 1'b1;
    while (items_sent < 1320) run_move();
    drain();

    if (sb.failures == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

endmodule

`default_nettype wire

FILE: filelist.f
+incdir+rtl
rtl/tams_pkg.sv
rtl/tams_axis_core.sv
rtl/trapezoidal_axis_motion_sequencer.sv
sim/trapezoidal_axis_motion_sequencer_test.sv
